// ----- hw/rtl/b64d_pkg.sv -----
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int MAX_DECODED_BYTES = 65535;
    localparam int CNT_W = $clog2(MAX_DECODED_BYTES + 2);
    localparam int CMP_W = (CNT_W + 1 > 17) ? CNT_W + 1 : 17;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
    localparam logic [2:0] ST_BAD_CHAR   = 3'd2;
    localparam logic [2:0] ST_BAD_PAD    = 3'd3;
    localparam logic [2:0] ST_OVER_LIMIT = 3'd4;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_beat_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [15:0] byte_count;
        logic        is_last;
    } out_beat_t;

    // bytes of one quartet still to send, plus an optional closing status
    typedef struct packed {
        logic [2:0]  byte_mask;
        logic [23:0] triple;
        logic        has_status;
        logic [2:0]  status;
        logic [15:0] byte_count;
    } work_t;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FIFO_LVL_W-1:0] level;
    } fifo_stat_t;

endpackage

// ----- hw/rtl/b64d_front.sv -----
`timescale 1ns / 1ps

module b64d_front
    import b64d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    input  logic        q_full,
    output logic        q_wr_en,
    output work_t       q_wr_data
);

    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_DECODED_BYTES + 1);

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] t;
        logic [6:0] r;
        t = 8'd0;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5a) begin
            t = c - 8'h41;
            r = {1'b0, t[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            t = c - 8'h61 + 8'd26;
            r = {1'b0, t[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30 + 8'd52;
            r = {1'b0, t[5:0]};
        end else if (c == 8'h2b) begin
            r = 7'd62;
        end else if (c == 8'h2f) begin
            r = 7'd63;
        end
        return r;
    endfunction

    logic [15:0]      limit_reg;
    logic [1:0]       pos_reg, pos_next;
    logic [17:0]      held_reg, held_next;
    logic             third_pad_reg, third_pad_next;
    logic             bad_seen_reg, bad_seen_next;
    logic [2:0]       first_err_reg, first_err_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             accept;
    logic [6:0]       v;
    logic             pad;
    logic             not_sx;
    logic             bad4;
    logic [2:0]       err;
    logic             fire;
    logic [1:0]       nbytes;
    logic [5:0]       s_val;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] lim_ext;
    logic [CMP_W-1:0] total;
    logic [CMP_W-1:0] step;
    logic [CNT_W-1:0] count_upd;
    logic [2:0]       mask;
    logic [1:0]       pos_after;
    logic [2:0]       st;
    logic [15:0]      cnt_out;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign v       = sextet_of(s_data.char_code);
    assign pad     = (s_data.char_code == 8'h3d);
    assign not_sx  = v[6];
    assign cnt_ext = CMP_W'(count_reg);
    assign lim_ext = CMP_W'(limit_reg);

    always_comb begin
        bad4   = !pad && not_sx;
        err    = ST_OK;
        if ((third_pad_reg || pad) && !s_data.last_char) begin
            err = ST_BAD_PAD;
        end else if (third_pad_reg && !pad) begin
            err = ST_BAD_PAD;
        end else if (bad_seen_reg || bad4) begin
            err = ST_BAD_CHAR;
        end
        nbytes = third_pad_reg ? 2'd1 : (pad ? 2'd2 : 2'd3);
        fire   = (pos_reg == 2'd3) && (first_err_reg == ST_OK) && (err == ST_OK);
        step   = '0;
        for (int i = 0; i < 3; i++) begin
            // counter value after this byte, held at its ceiling
            step = cnt_ext + CMP_W'(i + 1);
            if (step > CMP_W'(CNT_SAT)) begin
                step = CMP_W'(CNT_SAT);
            end
            mask[i] = fire && (i < int'(nbytes)) && (step <= lim_ext);
        end
        total = cnt_ext + CMP_W'(nbytes);
        count_upd = (total > CMP_W'(CNT_SAT)) ? CNT_SAT : total[CNT_W-1:0];
    end

    always_comb begin
        pos_next       = pos_reg;
        held_next      = held_reg;
        third_pad_next = third_pad_reg;
        bad_seen_next  = bad_seen_reg;
        first_err_next = first_err_reg;
        count_next     = count_reg;
        s_val          = not_sx ? 6'd0 : v[5:0];
        if (pos_reg == 2'd3) begin
            pos_next       = 2'd0;
            held_next      = 18'd0;
            third_pad_next = 1'b0;
            bad_seen_next  = 1'b0;
            if (first_err_reg == ST_OK && err != ST_OK) begin
                first_err_next = err;
            end
            if (fire) begin
                count_next = count_upd;
            end
        end else begin
            pos_next = pos_reg + 2'd1;
            if (pos_reg == 2'd2) begin
                third_pad_next = pad;
                if (!pad && not_sx) begin
                    bad_seen_next = 1'b1;
                end
                held_next = {held_reg[17:6], s_val};
            end else begin
                if (not_sx) begin
                    bad_seen_next = 1'b1;
                end
                if (pos_reg == 2'd0) begin
                    held_next = {s_val, held_reg[11:0]};
                end else begin
                    held_next = {held_reg[17:12], s_val, held_reg[5:0]};
                end
            end
        end
    end

    always_comb begin
        pos_after = pos_next;
        if (pos_after != 2'd0) begin
            st = ST_BAD_LENGTH;
        end else if (first_err_next != ST_OK) begin
            st = first_err_next;
        end else if (CMP_W'(count_next) > lim_ext) begin
            st = ST_OVER_LIMIT;
        end else begin
            st = ST_OK;
        end
        cnt_out = (CMP_W'(count_next) > CMP_W'(16'hffff)) ? 16'hffff
                                                          : 16'(count_next);
        q_wr_data.byte_mask  = mask;
        q_wr_data.triple     = {held_reg, (pad || bad4) ? 6'd0 : v[5:0]};
        q_wr_data.has_status = s_data.last_char;
        q_wr_data.status     = st;
        q_wr_data.byte_count = cnt_out;
        q_wr_en = accept && ((mask != 3'd0) || s_data.last_char);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= 16'hffff;
            pos_reg       <= 2'd0;
            held_reg      <= 18'd0;
            third_pad_reg <= 1'b0;
            bad_seen_reg  <= 1'b0;
            first_err_reg <= ST_OK;
            count_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (accept) begin
                if (s_data.last_char) begin
                    pos_reg       <= 2'd0;
                    held_reg      <= 18'd0;
                    third_pad_reg <= 1'b0;
                    bad_seen_reg  <= 1'b0;
                    first_err_reg <= ST_OK;
                    count_reg     <= '0;
                end else begin
                    pos_reg       <= pos_next;
                    held_reg      <= held_next;
                    third_pad_reg <= third_pad_next;
                    bad_seen_reg  <= bad_seen_next;
                    first_err_reg <= first_err_next;
                    count_reg     <= count_next;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/b64d_fifo.sv -----
`timescale 1ns / 1ps

module b64d_fifo
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  work_t      wr_data,
    input  logic       rd_en,
    output logic       rd_valid,
    output work_t      rd_data,
    output fifo_stat_t stat
);

    work_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_LVL_W-1:0] level_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign stat.full  = (level_reg == FIFO_LVL_W'(FIFO_DEPTH));
    assign stat.empty = (level_reg == '0);
    assign stat.level = level_reg;
    assign rd_valid   = !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                level_reg <= level_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/b64d_back.sv -----
`timescale 1ns / 1ps

module b64d_back
    import b64d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  work_t     q_data,
    output logic      q_rd_en,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    work_t     cur_reg, cur_next;
    logic      cur_valid_reg, cur_valid_next;
    logic      m_valid_reg, m_valid_next;
    out_beat_t m_data_reg;

    logic      out_free;
    logic      emit;
    logic      sel_byte;
    logic [7:0] byte_sel;
    logic [2:0] rem_mask;
    logic      rem_status;
    logic      rem_empty;
    logic      pop;
    out_beat_t beat;

    always_comb begin
        sel_byte = 1'b1;
        byte_sel = cur_reg.triple[23:16];
        rem_mask = cur_reg.byte_mask;
        priority if (cur_reg.byte_mask[0]) begin
            rem_mask[0] = 1'b0;
        end else if (cur_reg.byte_mask[1]) begin
            byte_sel    = cur_reg.triple[15:8];
            rem_mask[1] = 1'b0;
        end else if (cur_reg.byte_mask[2]) begin
            byte_sel    = cur_reg.triple[7:0];
            rem_mask[2] = 1'b0;
        end else begin
            sel_byte = 1'b0;
        end
        rem_status = cur_reg.has_status && sel_byte;
        rem_empty  = (rem_mask == 3'd0) && !rem_status;

        out_free = !m_valid_reg || m_ready;
        emit     = out_free && cur_valid_reg;
        pop      = q_valid && (!cur_valid_reg || (emit && rem_empty));

        if (sel_byte) begin
            beat.kind       = KIND_BYTE;
            beat.data_byte  = byte_sel;
            beat.status     = ST_OK;
            beat.byte_count = 16'd0;
        end else begin
            beat.kind       = KIND_STATUS;
            beat.data_byte  = 8'd0;
            beat.status     = cur_reg.status;
            beat.byte_count = cur_reg.byte_count;
        end
        beat.is_last = rem_empty;

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (pop) begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
        end else if (emit) begin
            cur_next.byte_mask  = rem_mask;
            cur_next.has_status = rem_status;
            cur_valid_next      = !rem_empty;
        end

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign q_rd_en = pop;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (emit) begin
            m_data_reg <= beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

endmodule

// ----- hw/rtl/base64_strict_decoder_unit.sv -----
`timescale 1ns / 1ps
// channel   | ports                        | beat
// ----------+------------------------------+------------------------------------------
// input     | s_valid s_ready s_data       | one text character, last flag
// result    | m_valid m_ready m_data       | one decoded byte or the closing status
// config    | cfg_wr_en cfg_wr_data        | buffer limit, taken at once
//
// one character a cycle enters while the queue is not full; a quartet is classified and decoded in the cycle it ends
// results leave one a cycle from the output register while m_ready is high, set by the back-end sequencer
// a four-entry queue between them takes bursts of up to four results per character
// reset is synchronous, active low, and sets the buffer limit to 65535
// s_ready drops only while the queue is full; m_ready low holds the output beat

module base64_strict_decoder_unit
    import b64d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data
);

    logic       q_wr_en;
    work_t      q_wr_data;
    logic       q_rd_en;
    logic       q_valid;
    work_t      q_rd_data;
    fifo_stat_t q_stat;

    b64d_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_full      (q_stat.full),
        .q_wr_en     (q_wr_en),
        .q_wr_data   (q_wr_data)
    );

    b64d_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .rd_en    (q_rd_en),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data),
        .stat     (q_stat)
    );

    b64d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_rd_data),
        .q_rd_en (q_rd_en),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a status beat always closes the results of its character
    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_STATUS) |-> m_data.is_last)
        else $error("status beat without is_last");

    // byte beats carry no status and no count
    a_byte_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_BYTE) |->
            (m_data.status == ST_OK) && (m_data.byte_count == 16'd0))
        else $error("byte beat with status or count");

    // input stalls only when the queue is full
    a_ready_follows_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == !q_stat.full)
        else $error("input ready does not follow queue level");

    // queued work items always hold at least one result
    a_queue_item_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr_en |-> (q_wr_data.byte_mask != 3'd0) || q_wr_data.has_status)
        else $error("empty work item queued");

    // a pop frees a slot, so level drops unless a write comes in with it
    a_level_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd_en && !q_wr_en |=> q_stat.level == $past(q_stat.level) - 1'b1)
        else $error("queue level wrong after pop");

endmodule
